[rtl/ghmc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ghmc_pkg: shared definitions for the grouped histogram mode block
// Request kinds, port packing widths, microcode word layout and the
// control program that sequences the datapath.
// ----------------------------------------------------------------------------
package ghmc_pkg;

  // Request kinds carried in s_tuser
  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_LOAD  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;
  localparam logic [1:0] KIND_QUERY = 2'd3;

  // Result status codes
  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_UNUSED = 1'b1;

  // Fixed field widths of the stream payloads
  localparam int KIND_W   = 2;
  localparam int GROUP_W  = 6;
  localparam int VIDX_W   = 4;
  localparam int LOAD_W   = 16;
  localparam int STATUS_W = 1;
  localparam int BEST_W   = 4;
  localparam int CONF_W   = 17;
  localparam int FRAC_W   = 16;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  // Divider step counter covers the FRAC_W fraction bits
  localparam int DCNT_W = 4;

  // Micro-operations
  localparam logic [3:0] OP_NOP        = 4'd0;
  localparam logic [3:0] OP_ACCEPT     = 4'd1;
  localparam logic [3:0] OP_READ       = 4'd2;
  localparam logic [3:0] OP_WRITE      = 4'd3;
  localparam logic [3:0] OP_CLEAR      = 4'd4;
  localparam logic [3:0] OP_SCAN_START = 4'd5;
  localparam logic [3:0] OP_SCAN       = 4'd6;
  localparam logic [3:0] OP_DIV_START  = 4'd7;
  localparam logic [3:0] OP_DIV_STEP   = 4'd8;
  localparam logic [3:0] OP_EMIT       = 4'd9;

  // Jump conditions: taken goes to target, otherwise fall through
  localparam logic [2:0] C_NEXT       = 3'd0;
  localparam logic [2:0] C_ALWAYS     = 3'd1;
  localparam logic [2:0] C_IS_CLEAR   = 3'd2;
  localparam logic [2:0] C_IS_QUERY   = 3'd3;
  localparam logic [2:0] C_CLR_MORE   = 3'd4;
  localparam logic [2:0] C_NOT_IN_USE = 3'd5;
  localparam logic [2:0] C_SCAN_MORE  = 3'd6;
  localparam logic [2:0] C_DIV_MORE   = 3'd7;

  // Result selects for OP_EMIT
  localparam logic [1:0] RES_ZERO  = 2'd0;
  localparam logic [1:0] RES_ERR   = 2'd1;
  localparam logic [1:0] RES_QUERY = 2'd2;

  // Program step labels
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] S_FETCH     = 4'd0;
  localparam logic [PC_W-1:0] S_CHK_CLEAR = 4'd1;
  localparam logic [PC_W-1:0] S_CHK_QUERY = 4'd2;
  localparam logic [PC_W-1:0] S_UPD_READ  = 4'd3;
  localparam logic [PC_W-1:0] S_UPD_WRITE = 4'd4;
  localparam logic [PC_W-1:0] S_CLR_LOOP  = 4'd5;
  localparam logic [PC_W-1:0] S_EMIT_ZERO = 4'd6;
  localparam logic [PC_W-1:0] S_Q_START   = 4'd7;
  localparam logic [PC_W-1:0] S_Q_SCAN    = 4'd8;
  localparam logic [PC_W-1:0] S_DIV_START = 4'd9;
  localparam logic [PC_W-1:0] S_DIV_LOOP  = 4'd10;
  localparam logic [PC_W-1:0] S_EMIT_QRY  = 4'd11;
  localparam logic [PC_W-1:0] S_EMIT_ERR  = 4'd12;
  localparam logic [PC_W-1:0] S_RST_CLR   = 4'd13;
  localparam logic [PC_W-1:0] S_RST_DONE  = 4'd14;
  localparam logic [PC_W-1:0] S_SPARE     = 4'd15;

  typedef struct packed {
    logic [3:0]      op;
    logic [1:0]      res;
    logic [2:0]      cond;
    logic [PC_W-1:0] target;
  } uword_t;

  // Control store
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{op: OP_NOP, res: RES_ZERO, cond: C_ALWAYS, target: S_FETCH};
    unique case (pc)
      S_FETCH:     w = '{op: OP_ACCEPT,     res: RES_ZERO,  cond: C_NEXT,
                         target: S_FETCH};
      S_CHK_CLEAR: w = '{op: OP_NOP,        res: RES_ZERO,  cond: C_IS_CLEAR,
                         target: S_CLR_LOOP};
      S_CHK_QUERY: w = '{op: OP_NOP,        res: RES_ZERO,  cond: C_IS_QUERY,
                         target: S_Q_START};
      S_UPD_READ:  w = '{op: OP_READ,       res: RES_ZERO,  cond: C_NEXT,
                         target: S_FETCH};
      S_UPD_WRITE: w = '{op: OP_WRITE,      res: RES_ZERO,  cond: C_ALWAYS,
                         target: S_EMIT_ZERO};
      S_CLR_LOOP:  w = '{op: OP_CLEAR,      res: RES_ZERO,  cond: C_CLR_MORE,
                         target: S_CLR_LOOP};
      S_EMIT_ZERO: w = '{op: OP_EMIT,       res: RES_ZERO,  cond: C_ALWAYS,
                         target: S_FETCH};
      S_Q_START:   w = '{op: OP_SCAN_START, res: RES_ZERO,  cond: C_NOT_IN_USE,
                         target: S_EMIT_ERR};
      S_Q_SCAN:    w = '{op: OP_SCAN,       res: RES_ZERO,  cond: C_SCAN_MORE,
                         target: S_Q_SCAN};
      S_DIV_START: w = '{op: OP_DIV_START,  res: RES_ZERO,  cond: C_NEXT,
                         target: S_FETCH};
      S_DIV_LOOP:  w = '{op: OP_DIV_STEP,   res: RES_ZERO,  cond: C_DIV_MORE,
                         target: S_DIV_LOOP};
      S_EMIT_QRY:  w = '{op: OP_EMIT,       res: RES_QUERY, cond: C_ALWAYS,
                         target: S_FETCH};
      S_EMIT_ERR:  w = '{op: OP_EMIT,       res: RES_ERR,   cond: C_ALWAYS,
                         target: S_FETCH};
      S_RST_CLR:   w = '{op: OP_CLEAR,      res: RES_ZERO,  cond: C_CLR_MORE,
                         target: S_RST_CLR};
      S_RST_DONE:  w = '{op: OP_NOP,        res: RES_ZERO,  cond: C_ALWAYS,
                         target: S_FETCH};
      S_SPARE:     w = '{op: OP_NOP,        res: RES_ZERO,  cond: C_ALWAYS,
                         target: S_FETCH};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

[rtl/ghmc_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ghmc_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ghmc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[rtl/grouped_histogram_mode_confidence.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// grouped_histogram_mode_confidence
// Per-group vote histogram with argmax and Q1.16 confidence, run by a
// small microcoded sequencer over one counter RAM.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                         handshake
//  s_       in   tuser: kind; tdata: group, value_index, load    tvalid/tready
//  m_       out  tuser: status; tdata: best_value, confidence    tvalid/tready
//
//  An add or load reads, writes and emits; a query makes one RAM read per
//  column, then one quotient bit per cycle (a group not in use skips both);
//  a clear zeroes one RAM word per cycle over DEPTH = NUM_GROUPS *
//  2**clog2(NUM_VALUES) words. After reset the same sweep and one more step
//  keep s_tready low. One item at a time; the result register lets the next
//  item be taken while a result waits on m_tready.
// ----------------------------------------------------------------------------
module grouped_histogram_mode_confidence #(
  parameter int NUM_GROUPS  = 64,
  parameter int NUM_VALUES  = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // [5:0] group, [9:6] value_index, [25:10] load_count, [31:26] zero
  input  wire logic [ghmc_pkg::IN_DATA_W-1:0]     s_tdata,
  // [1:0] kind
  input  wire logic [ghmc_pkg::KIND_W-1:0]        s_tuser,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // [3:0] best_value, [20:4] confidence, [23:21] zero
  output logic      [ghmc_pkg::OUT_DATA_W-1:0]    m_tdata,
  // [0] status
  output logic      [ghmc_pkg::STATUS_W-1:0]      m_tuser
);

  localparam int GW    = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int VW    = $clog2(NUM_VALUES);
  localparam int AW    = GW + VW;
  localparam int DEPTH = NUM_GROUPS * (1 << VW);
  localparam int GUW   = $clog2(NUM_GROUPS + 1);
  localparam int SW    = COUNT_WIDTH + VW;
  localparam int RCW   = VW + 1;

  // Sequencer
  logic [ghmc_pkg::PC_W-1:0] pc;
  logic [ghmc_pkg::PC_W-1:0] pc_next;
  ghmc_pkg::uword_t          uw;
  logic                      hold;
  logic                      jump;

  // Latched request
  logic [ghmc_pkg::KIND_W-1:0]  req_kind;
  logic [ghmc_pkg::GROUP_W-1:0] req_group;
  logic [ghmc_pkg::VIDX_W-1:0]  req_vidx;
  logic [ghmc_pkg::LOAD_W-1:0]  req_load;

  // Datapath registers
  logic [AW-1:0]             clr_addr;
  logic [GUW-1:0]            groups_in_use;
  logic [RCW-1:0]            rd_col;
  logic [VW-1:0]             acc_col;
  logic [COUNT_WIDTH-1:0]    maxc;
  logic [SW-1:0]             sum;
  logic [VW-1:0]             best;
  logic [SW-1:0]             rem;
  logic [ghmc_pkg::CONF_W-1:0] quot;
  logic [ghmc_pkg::DCNT_W-1:0] dcnt;

  // Result register
  logic                              out_valid;
  logic                              out_status;
  logic [ghmc_pkg::BEST_W-1:0]       out_best;
  logic [ghmc_pkg::CONF_W-1:0]       out_conf;

  // RAM ports
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [COUNT_WIDTH-1:0] ram_wdata;
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr;
  logic [COUNT_WIDTH-1:0] ram_rdata;

  // Decoded request
  logic [31:0]            g32;
  logic [31:0]            v32;
  logic [GW-1:0]          gi;
  logic [VW-1:0]          vi;
  logic                   g_ok;
  logic                   v_ok;
  logic                   in_use;
  logic [COUNT_WIDTH-1:0] upd_val;
  logic                   in_fire;
  logic                   out_busy;
  logic                   div_ge;
  logic [SW:0]            div_sh;
  logic                   div_bit;
  logic [SW-1:0]          max_ext;

  assign uw       = ghmc_pkg::ucode(pc);
  assign s_tready = (uw.op == ghmc_pkg::OP_ACCEPT);
  assign in_fire  = s_tvalid && s_tready;
  assign out_busy = out_valid && !m_tready;

  assign g32    = 32'(req_group);
  assign v32    = 32'(req_vidx);
  assign gi     = g32[GW-1:0];
  assign vi     = v32[VW-1:0];
  assign g_ok   = (g32 < 32'(NUM_GROUPS));
  assign v_ok   = (v32 < 32'(NUM_VALUES));
  assign in_use = (g32 < 32'(groups_in_use));

  // Add saturates; load keeps the low counter bits
  always_comb begin
    if (req_kind == ghmc_pkg::KIND_ADD) begin
      upd_val = (ram_rdata == {COUNT_WIDTH{1'b1}}) ? ram_rdata
                                                   : ram_rdata + COUNT_WIDTH'(1);
    end else begin
      upd_val = COUNT_WIDTH'(req_load);
    end
  end

  // Divider arithmetic
  assign max_ext = SW'(maxc);
  assign div_ge  = (max_ext >= sum);
  assign div_sh  = {rem, 1'b0};
  assign div_bit = (div_sh >= {1'b0, sum});

  // Jump condition
  always_comb begin
    unique case (uw.cond)
      ghmc_pkg::C_NEXT:       jump = 1'b0;
      ghmc_pkg::C_ALWAYS:     jump = 1'b1;
      ghmc_pkg::C_IS_CLEAR:   jump = (req_kind == ghmc_pkg::KIND_CLEAR);
      ghmc_pkg::C_IS_QUERY:   jump = (req_kind == ghmc_pkg::KIND_QUERY);
      ghmc_pkg::C_CLR_MORE:   jump = (clr_addr != AW'(DEPTH - 1));
      ghmc_pkg::C_NOT_IN_USE: jump = !in_use;
      ghmc_pkg::C_SCAN_MORE:  jump = (acc_col != VW'(NUM_VALUES - 1));
      ghmc_pkg::C_DIV_MORE:   jump = (dcnt != {ghmc_pkg::DCNT_W{1'b1}});
      default:                jump = 1'b0;
    endcase
  end

  // Stall on handshakes, else jump or step
  assign hold = ((uw.op == ghmc_pkg::OP_ACCEPT) && !in_fire) ||
                ((uw.op == ghmc_pkg::OP_EMIT) && out_busy);

  always_comb begin
    if (hold) begin
      pc_next = pc;
    end else if (jump) begin
      pc_next = uw.target;
    end else begin
      pc_next = pc + ghmc_pkg::PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ghmc_pkg::S_RST_CLR;
    end else begin
      pc <= pc_next;
    end
  end

  // RAM port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {gi, vi};
    ram_wdata = upd_val;
    ram_re    = 1'b0;
    ram_raddr = {gi, vi};
    unique case (uw.op)
      ghmc_pkg::OP_READ: begin
        ram_re = g_ok && v_ok;
      end
      ghmc_pkg::OP_WRITE: begin
        ram_we = g_ok && v_ok;
      end
      ghmc_pkg::OP_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      ghmc_pkg::OP_SCAN_START: begin
        ram_re    = in_use;
        ram_raddr = {gi, {VW{1'b0}}};
      end
      ghmc_pkg::OP_SCAN: begin
        ram_re    = (rd_col != RCW'(NUM_VALUES));
        ram_raddr = {gi, rd_col[VW-1:0]};
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  ghmc_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (DEPTH)
  ) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Latch the request
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_kind  <= s_tuser;
      req_group <= s_tdata[5:0];
      req_vidx  <= s_tdata[9:6];
      req_load  <= s_tdata[25:10];
    end
  end

  // Clear sweep address and group usage
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr      <= '0;
      groups_in_use <= '0;
    end else begin
      if (uw.op == ghmc_pkg::OP_CLEAR) begin
        clr_addr <= (clr_addr == AW'(DEPTH - 1)) ? '0 : clr_addr + AW'(1);
      end
      if ((uw.op == ghmc_pkg::OP_READ) && g_ok &&
          ((g32 + 32'd1) > 32'(groups_in_use))) begin
        groups_in_use <= GUW'(g32 + 32'd1);
      end
    end
  end

  // Row scan: issue one read per cycle, fold the previous read into max/sum
  always_ff @(posedge clk) begin
    unique case (uw.op)
      ghmc_pkg::OP_SCAN_START: begin
        rd_col  <= RCW'(1);
        acc_col <= '0;
        maxc    <= '0;
        sum     <= '0;
        best    <= '0;
      end
      ghmc_pkg::OP_SCAN: begin
        if (ram_re) begin
          rd_col <= rd_col + RCW'(1);
        end
        acc_col <= acc_col + VW'(1);
        sum     <= sum + SW'(ram_rdata);
        if (ram_rdata > maxc) begin
          maxc <= ram_rdata;
          best <= acc_col;
        end
      end
      default: begin
      end
    endcase
  end

  // Restoring division of max * 2^16 by the row sum, one bit per cycle
  always_ff @(posedge clk) begin
    unique case (uw.op)
      ghmc_pkg::OP_DIV_START: begin
        rem  <= div_ge ? max_ext - sum : max_ext;
        quot <= {{(ghmc_pkg::CONF_W-1){1'b0}}, div_ge};
        dcnt <= '0;
      end
      ghmc_pkg::OP_DIV_STEP: begin
        rem  <= div_bit ? SW'(div_sh - {1'b0, sum}) : SW'(div_sh);
        quot <= {quot[ghmc_pkg::CONF_W-2:0], div_bit};
        dcnt <= dcnt + ghmc_pkg::DCNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((uw.op == ghmc_pkg::OP_EMIT) && !out_busy) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((uw.op == ghmc_pkg::OP_EMIT) && !out_busy) begin
      unique case (uw.res)
        ghmc_pkg::RES_QUERY: begin
          out_status <= ghmc_pkg::STATUS_OK;
          out_best   <= ghmc_pkg::BEST_W'(best);
          out_conf   <= (sum == '0) ? '0 : quot;
        end
        ghmc_pkg::RES_ERR: begin
          out_status <= ghmc_pkg::STATUS_UNUSED;
          out_best   <= '0;
          out_conf   <= '0;
        end
        default: begin
          out_status <= ghmc_pkg::STATUS_OK;
          out_best   <= '0;
          out_conf   <= '0;
        end
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {3'b000, out_conf, out_best};

endmodule
`default_nettype wire

[dv/tb_grouped_histogram_mode_confidence.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grouped_histogram_mode_confidence
// Streams add, load, clear and query requests into the vote histogram and
// checks every result against a cycle-free model of the counter table. The
// model tracks the table and the groups in use, and computes the argmax and
// the Q1.16 share of each queried row. Both stream sides idle at random, and
// one long output hold-off backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_grouped_histogram_mode_confidence;

  localparam int NGRP        = 64;
  localparam int NVAL        = 16;
  localparam int RAND_ITEMS  = 1750;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_WAIT  = 60;
  localparam int QUIET_LO    = 600;
  localparam int QUIET_HI    = 900;
  localparam int HOLD_AT     = 1100;
  localparam int HOLD_LEN    = 400;

  typedef struct packed {
    logic [ghmc_pkg::KIND_W-1:0]  kind;
    logic [ghmc_pkg::GROUP_W-1:0] group;
    logic [ghmc_pkg::VIDX_W-1:0]  vidx;
    logic [ghmc_pkg::LOAD_W-1:0]  load;
  } request_t;

  typedef struct packed {
    logic                        status;
    logic [ghmc_pkg::BEST_W-1:0] best;
    logic [ghmc_pkg::CONF_W-1:0] conf;
  } mode_result_t;

  logic                            clk;
  logic                            rst      = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  // [5:0] group, [9:6] value_index, [25:10] load_count, [31:26] zero
  logic [ghmc_pkg::IN_DATA_W-1:0]  s_tdata  = '0;
  // [1:0] kind
  logic [ghmc_pkg::KIND_W-1:0]     s_tuser  = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  // [3:0] best_value, [20:4] confidence, [23:21] zero
  logic [ghmc_pkg::OUT_DATA_W-1:0] m_tdata;
  // [0] status
  logic [ghmc_pkg::STATUS_W-1:0]   m_tuser;

  // Model state: vote table and groups in use
  logic [15:0]  tally [NGRP][NVAL];
  logic [6:0]   rows_in_use;

  request_t     pending [$];
  mode_result_t expected_modes [$];
  logic         in_taken   = 1'b0;
  int           accepted   = 0;
  int           errors     = 0;
  int           stall_cycles = 0;
  int           hold_left  = 0;
  logic         held       = 1'b0;

  grouped_histogram_mode_confidence dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one request to the table and return the result it should produce
  function automatic mode_result_t tally_request(input request_t rq);
    mode_result_t r;
    longint unsigned peak;
    longint unsigned total;
    r = '{status: ghmc_pkg::STATUS_OK, best: '0, conf: '0};
    case (rq.kind)
      ghmc_pkg::KIND_ADD, ghmc_pkg::KIND_LOAD: begin
        if (7'(rq.group) + 7'd1 > rows_in_use) rows_in_use = 7'(rq.group) + 7'd1;
        if (rq.kind == ghmc_pkg::KIND_LOAD) begin
          tally[rq.group][rq.vidx] = rq.load;
        end else if (tally[rq.group][rq.vidx] != 16'hFFFF) begin
          tally[rq.group][rq.vidx] = tally[rq.group][rq.vidx] + 16'd1;
        end
      end
      ghmc_pkg::KIND_CLEAR: begin
        foreach (tally[g, v]) tally[g][v] = '0;
      end
      default: begin
        if (7'(rq.group) >= rows_in_use) begin
          r.status = ghmc_pkg::STATUS_UNUSED;
        end else begin
          peak  = tally[rq.group][0];
          total = 0;
          for (int v = 0; v < NVAL; v++) begin
            if (tally[rq.group][v] > peak) begin
              peak   = tally[rq.group][v];
              r.best = ghmc_pkg::VIDX_W'(v);
            end
            total += tally[rq.group][v];
          end
          if (total != 0) r.conf = ghmc_pkg::CONF_W'((peak << ghmc_pkg::FRAC_W) / total);
        end
      end
    endcase
    return r;
  endfunction

  task automatic queue_request(input logic [ghmc_pkg::KIND_W-1:0] k, input int g,
                               input int v, input int c);
    request_t rq;
    rq = '{kind: k, group: ghmc_pkg::GROUP_W'(g), vidx: ghmc_pkg::VIDX_W'(v),
           load: ghmc_pkg::LOAD_W'(c)};
    pending = {pending, rq};
  endtask

  // Stimulus, reset and end of run
  initial begin : stimulus
    int sel;
    int grp;
    int cnt;
    // Queries before any group is in use
    queue_request(ghmc_pkg::KIND_QUERY, 0, 0, 0);
    queue_request(ghmc_pkg::KIND_QUERY, 63, 15, 16'hFFFF);
    // Saturation, single nonzero column, and a tie
    queue_request(ghmc_pkg::KIND_LOAD, 0, 0, 16'hFFFF);
    queue_request(ghmc_pkg::KIND_ADD, 0, 0, 0);
    queue_request(ghmc_pkg::KIND_QUERY, 0, 0, 0);
    queue_request(ghmc_pkg::KIND_LOAD, 0, 15, 16'hFFFF);
    queue_request(ghmc_pkg::KIND_QUERY, 0, 0, 0);
    queue_request(ghmc_pkg::KIND_QUERY, 5, 0, 0);
    // Highest group, then an in-use row with a zero sum
    queue_request(ghmc_pkg::KIND_ADD, 63, 15, 0);
    queue_request(ghmc_pkg::KIND_QUERY, 63, 0, 0);
    queue_request(ghmc_pkg::KIND_QUERY, 10, 0, 0);
    queue_request(ghmc_pkg::KIND_LOAD, 10, 7, 3);
    queue_request(ghmc_pkg::KIND_LOAD, 10, 3, 3);
    queue_request(ghmc_pkg::KIND_LOAD, 10, 9, 1);
    queue_request(ghmc_pkg::KIND_QUERY, 10, 0, 0);
    queue_request(ghmc_pkg::KIND_LOAD, 20, 5, 16'hAAAA);
    queue_request(ghmc_pkg::KIND_LOAD, 20, 6, 16'h5555);
    queue_request(ghmc_pkg::KIND_QUERY, 20, 0, 0);
    // Clear keeps groups in use
    queue_request(ghmc_pkg::KIND_CLEAR, 0, 0, 0);
    queue_request(ghmc_pkg::KIND_QUERY, 0, 0, 0);
    queue_request(ghmc_pkg::KIND_QUERY, 63, 0, 0);
    queue_request(ghmc_pkg::KIND_ADD, 0, 2, 0);
    queue_request(ghmc_pkg::KIND_QUERY, 0, 0, 0);

    // Random traffic, mostly on a few busy groups so rows build up votes
    for (int n = 0; n < RAND_ITEMS; n++) begin
      sel = $urandom_range(0, 199);
      grp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 7);
      cnt = $urandom_range(0, 65535);
      if (sel < 2) begin
        queue_request(ghmc_pkg::KIND_CLEAR, grp, $urandom_range(0, 15), cnt);
      end else if (sel < 52) begin
        queue_request(ghmc_pkg::KIND_QUERY, grp, $urandom_range(0, 15), cnt);
      end else if (sel < 82) begin
        case ($urandom_range(0, 3))
          0: cnt = 16'hFFFF;
          1: cnt = $urandom_range(0, 20);
          default: ;
        endcase
        queue_request(ghmc_pkg::KIND_LOAD, grp, $urandom_range(0, 15), cnt);
      end else begin
        queue_request(ghmc_pkg::KIND_ADD, grp,
                      ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15)
                                                  : $urandom_range(0, 3), cnt);
      end
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for all items to go in and all results to come out
    while (pending.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_modes.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (errors == 0 && expected_modes.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Model reset state
  initial begin
    foreach (tally[g, v]) tally[g][v] = '0;
    rows_in_use = '0;
  end

  // Drive requests: hold while offered and not taken, else advance or idle
  always @(negedge clk) begin : feed
    request_t nxt;
    logic     offer;
    offer = 1'b0;
    if (!rst && (!s_tvalid || in_taken)) begin
      if (pending.size() > 0 &&
          ((accepted >= QUIET_LO && accepted < QUIET_HI) || $urandom_range(0, 99) >= 7)) begin
        nxt = pending.pop_front();
        offer = 1'b1;
        s_tdata <= ghmc_pkg::IN_DATA_W'({nxt.load, nxt.vidx, nxt.group});
        s_tuser <= nxt.kind;
      end
      s_tvalid <= offer;
    end
  end

  // Result side: random stalls and one long hold-off
  always @(negedge clk) begin : drain
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (!held && accepted >= HOLD_AT) begin
      held      <= 1'b1;
      hold_left <= HOLD_LEN;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= (accepted >= QUIET_LO && accepted < QUIET_HI) ||
                  ($urandom_range(0, 99) >= 7);
    end
  end

  // Check results in order, then predict for newly accepted items
  always @(posedge clk) begin : score
    mode_result_t want;
    request_t     rq;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_tvalid && s_tready;
      if (m_tvalid && m_tready) begin
        if (expected_modes.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          want = expected_modes.pop_front();
          if (m_tuser[0] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_tuser[0]);
            errors++;
          end
          if (m_tdata[3:0] !== want.best) begin
            $error("best_value: expected %0d, got %0d", want.best, m_tdata[3:0]);
            errors++;
          end
          if (m_tdata[20:4] !== want.conf) begin
            $error("confidence: expected %0d, got %0d", want.conf, m_tdata[20:4]);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        rq.kind  = s_tuser;
        rq.group = s_tdata[5:0];
        rq.vidx  = s_tdata[9:6];
        rq.load  = s_tdata[25:10];
        want = tally_request(rq);
        expected_modes = {expected_modes, want};
        accepted <= accepted + 1;
      end
    end
  end

  // Watchdog: end the run if no item moves for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

endmodule
